FILE: rtl/forro_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// forro_pkg: shared types and constants for the Forro14 stream cipher
// Holds state constants, register indexes, controller states and the
// command and status structs between controller and datapath.
// ----------------------------------------------------------------------------
package forro_pkg;

  localparam logic [31:0] SIGMA_6  = 32'h746C6F76;
  localparam logic [31:0] SIGMA_7  = 32'h61616461;
  localparam logic [31:0] SIGMA_14 = 32'h72626173;
  localparam logic [31:0] SIGMA_15 = 32'h61636E61;

  localparam int RotA = 10;
  localparam int RotB = 27;
  localparam int RotC = 8;

  localparam logic [2:0] REG_KEY01   = 3'd0;
  localparam logic [2:0] REG_KEY23   = 3'd1;
  localparam logic [2:0] REG_KEY89   = 3'd2;
  localparam logic [2:0] REG_KEY1011 = 3'd3;
  localparam logic [2:0] REG_NONCE_L = 3'd4;
  localparam logic [2:0] REG_NONCE_H = 3'd5;
  localparam logic [2:0] REG_START   = 3'd6;
  localparam logic [2:0] REG_IETF    = 3'd7;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT,
    ST_ROUND,
    ST_FEED,
    ST_OUT
  } ctrl_state_t;

  typedef struct packed {
    logic load_init;
    logic qr_step;
    logic feed;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic need_block;
  } dp_stat_t;

  function automatic logic [31:0] rotl(input logic [31:0] v, input int c);
    rotl = (v << c) | (v >> (32 - c));
  endfunction

endpackage

FILE: rtl/forro_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// forro_if: stream and configuration channel interfaces
// Valid/ready channels; a beat moves when both are high.
// ----------------------------------------------------------------------------
interface forro_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] message_word;
  logic [3:0]  valid_bytes;
  logic        end_of_message;
  modport source (output valid, message_word, valid_bytes, end_of_message, input ready);
  modport sink   (input valid, message_word, valid_bytes, end_of_message, output ready);
endinterface

interface forro_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] cipher_word;
  logic [3:0]  valid_bytes_out;
  logic        end_of_message_out;
  modport source (output valid, cipher_word, valid_bytes_out, end_of_message_out,
                  input ready);
  modport sink   (input valid, cipher_word, valid_bytes_out, end_of_message_out,
                  output ready);
endinterface

interface forro_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [63:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/forro_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// forro_ctrl: sequencer for the Forro14 block
// Steps accept, block init, quarter-rounds, feed-forward and output.
// ----------------------------------------------------------------------------
module forro_ctrl import forro_pkg::*; #(
  parameter int ROUND_COUNT = 14
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  logic     out_ready,
  output logic     out_valid,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  localparam int QrTotal = ((ROUND_COUNT + 1) / 2) * 8;
  localparam int QW = $clog2(QrTotal + 1);

  ctrl_state_t state, state_next;
  logic [QW-1:0] qr_cnt;

  // hold state and count quarter-rounds
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      qr_cnt <= '0;
    end else begin
      state <= state_next;
      if (state == ST_INIT) qr_cnt <= '0;
      else if (state == ST_ROUND) qr_cnt <= qr_cnt + 1'b1;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (in_valid) state_next = stat.need_block ? ST_INIT : ST_OUT;
      ST_INIT:  state_next = ST_ROUND;
      ST_ROUND: if (qr_cnt == QW'(QrTotal - 1)) state_next = ST_FEED;
      ST_FEED:  state_next = ST_OUT;
      ST_OUT:   if (out_ready) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    unique case (state)
      ST_IDLE:  cmd.load_init = in_valid && stat.need_block;
      ST_INIT:  ;
      ST_ROUND: cmd.qr_step = 1'b1;
      ST_FEED:  cmd.feed = 1'b1;
      ST_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          in_ready = 1'b1;
          cmd.emit = 1'b1;
        end
      end
      default: ;
    endcase
  end

endmodule

FILE: rtl/forro_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// forro_dp: Forro14 datapath
// Config registers, counter, 16-word state with one quarter-round unit,
// keystream block and the output XOR.
// ----------------------------------------------------------------------------
module forro_dp import forro_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic [63:0] message_word,
  input  logic [3:0]  valid_bytes,
  input  logic        end_of_message,
  input  dp_cmd_t     cmd,
  output dp_stat_t    stat,
  output logic [63:0] cipher_word,
  output logic [3:0]  valid_bytes_out,
  output logic        end_of_message_out
);

  logic [63:0] key01, key23, key89, key1011, nonce_low, start_counter;
  logic [31:0] nonce_high;
  logic        ietf;
  logic [31:0] ctr_lo, ctr_hi;
  logic [31:0] x [16];
  logic [31:0] init [16];
  logic [31:0] ks [16];
  logic [2:0]  word_pos, qr_sel;
  logic        message_open;
  logic [31:0] c_lo, c_hi;
  logic [3:0]  ia, ib, ic, id, ie;
  logic [31:0] a0, b0, c0, d0, e0, d1, c1, b1, a1, e1, d2, c2, b2, a2;
  logic [63:0] mask, ksw;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      key01 <= '0; key23 <= '0; key89 <= '0; key1011 <= '0;
      nonce_low <= '0; nonce_high <= '0; start_counter <= '0; ietf <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_KEY01:   key01 <= cfg_data;
        REG_KEY23:   key23 <= cfg_data;
        REG_KEY89:   key89 <= cfg_data;
        REG_KEY1011: key1011 <= cfg_data;
        REG_NONCE_L: nonce_low <= cfg_data;
        REG_NONCE_H: nonce_high <= cfg_data[31:0];
        REG_START:   start_counter <= cfg_data;
        REG_IETF:    ietf <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign stat.need_block = !message_open || word_pos == 3'd0;

  // counter as seen by this block: reload at message start
  assign c_lo = message_open ? ctr_lo : start_counter[31:0];
  assign c_hi = message_open ? ctr_hi : (ietf ? nonce_low[31:0] : start_counter[63:32]);

  // starting state
  always_comb begin
    init[0]  = key01[31:0];   init[1]  = key01[63:32];
    init[2]  = key23[31:0];   init[3]  = key23[63:32];
    init[4]  = ctr_lo;        init[5]  = ctr_hi;
    init[6]  = SIGMA_6;       init[7]  = SIGMA_7;
    init[8]  = key89[31:0];   init[9]  = key89[63:32];
    init[10] = key1011[31:0]; init[11] = key1011[63:32];
    init[12] = ietf ? nonce_low[63:32] : nonce_low[31:0];
    init[13] = ietf ? nonce_high : nonce_low[63:32];
    init[14] = SIGMA_14;      init[15] = SIGMA_15;
  end

  // quarter-round index selection
  always_comb begin
    ia = {2'b00, qr_sel[1:0]};
    ib = qr_sel[2] ? {2'b01, 2'(qr_sel[1:0] + 2'd1)} : {2'b01, qr_sel[1:0]};
    ic = qr_sel[2] ? {2'b10, 2'(qr_sel[1:0] + 2'd2)} : {2'b10, qr_sel[1:0]};
    id = qr_sel[2] ? {2'b11, 2'(qr_sel[1:0] + 2'd3)} : {2'b11, qr_sel[1:0]};
    ie = {2'b00, 2'(qr_sel[1:0] + 2'd3)};
  end

  // one five-word quarter-round
  always_comb begin
    a0 = x[ia]; b0 = x[ib]; c0 = x[ic]; d0 = x[id]; e0 = x[ie];
    d1 = d0 + e0;
    c1 = c0 ^ d1;
    b1 = rotl(b0 + c1, RotA);
    a1 = a0 + b1;
    e1 = e0 ^ a1;
    d2 = rotl(d1 + e1, RotB);
    c2 = c1 + d2;
    b2 = b1 ^ c2;
    a2 = rotl(a1 + b2, RotC);
  end

  // advance round state, counter and position
  always_ff @(posedge clk) begin
    if (rst) begin
      ctr_lo <= '0; ctr_hi <= '0; word_pos <= '0; message_open <= 1'b0; qr_sel <= '0;
    end else begin
      if (cmd.load_init) begin
        ctr_lo <= c_lo;
        ctr_hi <= c_hi;
        word_pos <= 3'd0;
        message_open <= 1'b1;
        qr_sel <= '0;
      end
      if (cmd.qr_step) qr_sel <= qr_sel + 3'd1;
      if (cmd.feed) begin
        ctr_lo <= ctr_lo + 32'd1;
        if (ctr_lo == 32'hFFFF_FFFF) ctr_hi <= ctr_hi + 32'd1;
      end
      if (cmd.emit) begin
        word_pos <= word_pos + 3'd1;
        if (end_of_message) message_open <= 1'b0;
      end
    end
  end

  // working words and keystream block
  always_ff @(posedge clk) begin
    if (cmd.qr_step) begin
      x[ia] <= a2; x[ib] <= b2; x[ic] <= c2; x[id] <= d2; x[ie] <= e1;
    end else if (cmd.load_init || cmd.feed == 1'b0) begin
      if (!cmd.emit) x <= init;
    end
    if (cmd.feed) begin
      for (int i = 0; i < 16; i++) ks[i] <= x[i] + init[i];
    end
  end

  // output word
  assign ksw = {ks[{word_pos, 1'b1}], ks[{word_pos, 1'b0}]};
  assign mask = (valid_bytes >= 4'd8) ? '1 :
                ((64'd1 << {valid_bytes[2:0], 3'b000}) - 64'd1);
  assign cipher_word        = (message_word ^ ksw) & mask;
  assign valid_bytes_out    = valid_bytes;
  assign end_of_message_out = end_of_message;

endmodule

FILE: rtl/arx_stream_cipher_14_rounds.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arx_stream_cipher_14_rounds: Forro14 stream cipher, one 64-bit word a beat
// A word that opens a 64-byte keystream block waits through block init, the
// quarter-rounds of the single quarter-round unit, one quarter-round per
// cycle, and feed-forward; other words go straight to output. The input
// word is held on the port while its result is shown and is taken with it.
// ----------------------------------------------------------------------------
module arx_stream_cipher_14_rounds import forro_pkg::*; #(
  parameter int ROUND_COUNT = 14
) (
  input logic   clk,
  input logic   rst,
  forro_in_if.sink   in_ch,
  forro_out_if.source out_ch,
  forro_cfg_if.sink  cfg
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  assign cfg.ready = 1'b1;

  forro_ctrl #(.ROUND_COUNT(ROUND_COUNT)) u_ctrl (
    .clk, .rst,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_ready(out_ch.ready), .out_valid(out_ch.valid),
    .stat, .cmd
  );

  forro_dp u_dp (
    .clk, .rst,
    .cfg_we(cfg.valid), .cfg_index(cfg.index), .cfg_data(cfg.data),
    .message_word(in_ch.message_word), .valid_bytes(in_ch.valid_bytes),
    .end_of_message(in_ch.end_of_message),
    .cmd, .stat,
    .cipher_word(out_ch.cipher_word), .valid_bytes_out(out_ch.valid_bytes_out),
    .end_of_message_out(out_ch.end_of_message_out)
  );

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench for the Forro14 stream cipher
// Drives message words and register writes, predicts every cipher word
// from its own keystream generator, and checks results in order.
// ----------------------------------------------------------------------------
module tb_top;
  import forro_pkg::*;

  typedef struct packed {
    logic [63:0] word;
    logic [3:0]  nbytes;
    logic        last;
  } cipher_beat_t;

  // Scoreboard: keeps cipher state and the queue of expected words
  class cipher_scoreboard;
    logic [63:0] key01, key23, key89, key1011, nonce_l, start_ctr;
    logic [31:0] nonce_h;
    logic        ietf;
    logic [31:0] ctr_lo, ctr_hi;
    logic [31:0] ks_block [16];
    logic [2:0]  pos;
    bit          open;
    cipher_beat_t expected_q[$];
    int          errors;

    function void write_reg(logic [2:0] idx, logic [63:0] val);
      case (idx)
        REG_KEY01:   key01 = val;
        REG_KEY23:   key23 = val;
        REG_KEY89:   key89 = val;
        REG_KEY1011: key1011 = val;
        REG_NONCE_L: nonce_l = val;
        REG_NONCE_H: nonce_h = val[31:0];
        REG_START:   start_ctr = val;
        REG_IETF:    ietf = val[0];
        default: ;
      endcase
    endfunction

    function logic [31:0] rol(logic [31:0] v, int c);
      return (v << c) | (v >> (32 - c));
    endfunction

    function void mix(ref logic [31:0] x[16], input int a, int b, int c, int d, int e);
      x[d] += x[e];
      x[c] ^= x[d];
      x[b] = rol(x[b] + x[c], 10);
      x[a] += x[b];
      x[e] ^= x[a];
      x[d] = rol(x[d] + x[e], 27);
      x[c] += x[d];
      x[b] ^= x[c];
      x[a] = rol(x[a] + x[b], 8);
    endfunction

    function void next_block();
      logic [31:0] init [16];
      logic [31:0] x [16];
      init[0] = key01[31:0];   init[1] = key01[63:32];
      init[2] = key23[31:0];   init[3] = key23[63:32];
      init[4] = ctr_lo;        init[5] = ctr_hi;
      init[6] = 32'h746C6F76;  init[7] = 32'h61616461;
      init[8] = key89[31:0];   init[9] = key89[63:32];
      init[10] = key1011[31:0]; init[11] = key1011[63:32];
      init[12] = ietf ? nonce_l[63:32] : nonce_l[31:0];
      init[13] = ietf ? nonce_h : nonce_l[63:32];
      init[14] = 32'h72626173; init[15] = 32'h61636E61;
      x = init;
      for (int r = 0; r < 7; r++) begin
        mix(x, 0, 4, 8, 12, 3);
        mix(x, 1, 5, 9, 13, 0);
        mix(x, 2, 6, 10, 14, 1);
        mix(x, 3, 7, 11, 15, 2);
        mix(x, 0, 5, 10, 15, 3);
        mix(x, 1, 6, 11, 12, 0);
        mix(x, 2, 7, 8, 13, 1);
        mix(x, 3, 4, 9, 14, 2);
      end
      for (int i = 0; i < 16; i++) ks_block[i] = x[i] + init[i];
      ctr_lo += 32'd1;
      if (ctr_lo == 32'd0) ctr_hi += 32'd1;
    endfunction

    // Note an accepted message beat and queue its cipher word
    function void note_input(logic [63:0] msg, logic [3:0] nb, logic last);
      logic [63:0] ks, mask;
      cipher_beat_t exp_beat;
      if (!open) begin
        ctr_lo = start_ctr[31:0];
        ctr_hi = ietf ? nonce_l[31:0] : start_ctr[63:32];
        pos = 3'd0;
        open = 1'b1;
      end
      if (pos == 3'd0) next_block();
      ks = {ks_block[2 * pos + 1], ks_block[2 * pos]};
      mask = (nb >= 4'd8) ? '1 : ((64'd1 << (8 * nb)) - 64'd1);
      exp_beat.word = (msg ^ ks) & mask;
      exp_beat.nbytes = nb;
      exp_beat.last = last;
      expected_q.push_back(exp_beat);
      pos++;
      if (last) open = 1'b0;
    endfunction

    // Compare a result beat against the oldest expectation
    function void check_output(cipher_beat_t got);
      cipher_beat_t want;
      if (expected_q.size() == 0) begin
        report_mismatch("result beat with nothing expected", 64'd0, got.word);
        return;
      end
      want = expected_q.pop_front();
      if (got.word !== want.word) report_mismatch("cipher_word", want.word, got.word);
      if (got.nbytes !== want.nbytes)
        report_mismatch("valid_bytes_out", 64'(want.nbytes), 64'(got.nbytes));
      if (got.last !== want.last)
        report_mismatch("end_of_message_out", 64'(want.last), 64'(got.last));
    endfunction

    function void report_mismatch(string what, logic [63:0] want, logic [63:0] got);
      $display("MISMATCH %s: expected %h got %h at %0t", what, want, got, $realtime);
      errors++;
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  forro_in_if  in_ch();
  forro_out_if out_ch();
  forro_cfg_if cfg();

  arx_stream_cipher_14_rounds i_dut (
    .clk(clk), .rst(rst), .in_ch(in_ch.sink), .out_ch(out_ch.source), .cfg(cfg.sink)
  );

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  cipher_scoreboard sb = new();
  int unsigned cycle_cnt;
  int unsigned hold_off_cycles;
  bit          hold_req;
  bit          hold_taken;
  bit          rx_steady;
  bit          stim_done;

  initial begin
    in_ch.valid = 1'b0; in_ch.message_word = 64'd0; in_ch.valid_bytes = 4'd8;
    in_ch.end_of_message = 1'b0;
    out_ch.ready = 1'b0;
    cfg.valid = 1'b0; cfg.index = REG_KEY01; cfg.data = 64'd0;
    sb.key01 = 0; sb.key23 = 0; sb.key89 = 0; sb.key1011 = 0;
    sb.nonce_l = 0; sb.nonce_h = 0; sb.start_ctr = 0; sb.ietf = 0;
    sb.ctr_lo = 0; sb.ctr_hi = 0; sb.pos = 0; sb.open = 0; sb.errors = 0;
  end

  // Timeout watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == 1000000) begin
      $display("** arx_stream_cipher_14_rounds: FAILED **");
      $finish;
    end
  end

  // Monitor both channels; random or steady ready, with one long hold-off
  always @(posedge clk) begin
    if (!rst) begin
      if (in_ch.valid && in_ch.ready)
        sb.note_input(in_ch.message_word, in_ch.valid_bytes, in_ch.end_of_message);
      if (out_ch.valid && out_ch.ready)
        sb.check_output({out_ch.cipher_word, out_ch.valid_bytes_out,
                         out_ch.end_of_message_out});
      if (hold_req && !hold_taken) begin
        hold_taken <= 1'b1;
        hold_off_cycles <= 400;
        out_ch.ready <= 1'b0;
      end else if (hold_off_cycles != 0) begin
        hold_off_cycles <= hold_off_cycles - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= rx_steady ? 1'b1 : ($urandom_range(0, 5) == 0);
      end
    end
  end

  task automatic write_cfg(logic [2:0] idx, logic [63:0] val);
    in_ch.valid <= 1'b0;
    cfg.index <= idx;
    cfg.data <= val;
    cfg.valid <= 1'b1;
    do @(posedge clk); while (!cfg.ready);
    sb.write_reg(idx, val);
    cfg.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Offer one beat; valid stays up so a zero gap keeps beats back to back
  task automatic send_word(logic [63:0] msg, logic [3:0] nb, logic last, bit gaps);
    int gap;
    gap = gaps ? $urandom_range(0, 5) : 0;
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.message_word <= msg;
    in_ch.valid_bytes <= nb;
    in_ch.end_of_message <= last;
    in_ch.valid <= 1'b1;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    in_ch.valid <= 1'b0;
    while (sb.expected_q.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (80) @(posedge clk);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  task automatic random_setup(bit ietf_mode);
    write_cfg(REG_KEY01, rand64());
    write_cfg(REG_KEY23, rand64());
    write_cfg(REG_KEY89, rand64());
    write_cfg(REG_KEY1011, rand64());
    write_cfg(REG_NONCE_L, rand64());
    write_cfg(REG_NONCE_H, {32'h0, $urandom()});
    write_cfg(REG_START, ($urandom_range(0, 3) == 0) ? 64'h0000_0000_FFFF_FFFE : rand64());
    write_cfg(REG_IETF, {63'h0, ietf_mode});
  endtask

  // One message of random content; mostly full words, last word may be short
  task automatic send_message(int nwords, bit gaps);
    logic [3:0] nb;
    for (int w = 0; w < nwords; w++) begin
      nb = 4'd8;
      if (w == nwords - 1) nb = 4'($urandom_range(1, 8));
      else if ($urandom_range(0, 19) == 0) nb = 4'($urandom_range(0, 15));
      if ($urandom_range(0, 29) == 0) nb = 4'($urandom_range(0, 15));
      send_word(rand64(), nb, w == nwords - 1, gaps);
    end
  endtask

  initial begin
    int sent;
    int n;
    rx_steady = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: all-zero key/config, extremes of fields and valid counts
    send_word(64'h0, 4'd8, 1'b0, 1'b0);
    send_word('1, 4'd8, 1'b0, 1'b0);
    for (int v = 0; v <= 15; v++) send_word(64'hA5A5_5A5A_0F0F_F0F0, v[3:0], 1'b0, 1'b0);
    send_word('1, 4'd1, 1'b1, 1'b0);
    send_word('1, 4'd8, 1'b1, 1'b0);
    drain();

    // Extremes: all-ones registers, counter wrap in both layouts
    write_cfg(REG_KEY01, '1); write_cfg(REG_KEY23, '1);
    write_cfg(REG_KEY89, '1); write_cfg(REG_KEY1011, '1);
    write_cfg(REG_NONCE_L, '1); write_cfg(REG_NONCE_H, 64'hFFFF_FFFF);
    write_cfg(REG_START, '1); write_cfg(REG_IETF, 64'd1);
    send_message(20, 1'b1);
    write_cfg(REG_IETF, 64'd0);
    drain();
    send_message(20, 1'b1);
    drain();
    sent = 60;

    // Random phases with changing settings
    while (sent < 1950) begin
      random_setup(1'($urandom_range(0, 1)));
      rx_steady = ($urandom_range(0, 3) == 0);
      for (int m = 0; m < 6; m++) begin
        n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 24);
        if (m == 2 && sent > 600) hold_req = 1'b1;
        send_message(n, !rx_steady);
        sent += n;
      end
      // Pause until every expected result is back
      drain();
    end
    stim_done = 1;
  end

  // Final verdict
  initial begin
    wait (stim_done);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("** arx_stream_cipher_14_rounds: PASSED **");
    end else begin
      $display("** arx_stream_cipher_14_rounds: FAILED **");
    end
    $finish;
  end
endmodule
